// File: hw/rtl/fsp_pkg.sv
// Shared types, codes and arithmetic helpers of the fractional sample player.
package fsp_pkg;

	// Operation codes of a command transaction
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 21;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_STEREO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP_GAIN   = 3'd5;

	localparam int LEN_W = 17;
	localparam int STEP_W = 21;

	// Gain selection within the three-step gain chain
	localparam logic [1:0] G_TICK   = 2'd0;
	localparam logic [1:0] G_VEL    = 2'd1;
	localparam logic [1:0] G_MAKEUP = 2'd2;

	// Lane width: interpolated sample grows at most one bit per gain step
	localparam int GW = 21;
	localparam int GAIN_SHIFT = 15;
	localparam int GAIN_HALF = 1 << (GAIN_SHIFT - 1);

	typedef struct packed {
		logic [1:0]         op;
		logic [15:0]        write_index;
		logic signed [15:0] write_left;
		logic signed [15:0] write_right;
		logic [15:0]        tick_gain;
		logic               envelope_active;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
		logic signed [15:0] out_mix;
		logic               finished;
	} res_t;

	// x * g / 32768, rounded to nearest with ties upward
	function automatic logic signed [GW-1:0] gain_mul(input logic signed [GW-1:0] x,
			input logic [15:0] g);
		logic signed [GW+16:0] p;
		p = x * $signed({1'b0, g});
		p = p + (GW+17)'(GAIN_HALF);
		return GW'(p >>> GAIN_SHIFT);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [GW-1:0] x);
		logic signed [15:0] r;
		if (x > GW'(32767))
			r = 16'sh7FFF;
		else if (x < GW'(-32768))
			r = -16'sh8000;
		else
			r = x[15:0];
		return r;
	endfunction

endpackage

// File: hw/rtl/fsp_if.sv
// Channel interfaces of the fractional sample player: commands, results, configuration.
interface fsp_cmd_if;
	logic          valid;
	logic          ready;
	fsp_pkg::cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fsp_res_if;
	logic          valid;
	logic          ready;
	fsp_pkg::res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fsp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fsp_pkg::CFG_IDX_W-1:0]  index;
	logic [fsp_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/fractional_sample_player_top.sv
// Fractional sample player: one voice with linearly interpolated stereo playback.
//
// Channels: cmd takes write, start and tick transactions; res returns one result per
// tick; cfg writes the six configuration registers (always ready, one per cycle).
// A write transaction stores a stereo sample into the sample RAM in its accept cycle;
// a start transaction rewinds the voice in its accept cycle. Both give no result.
// A tick runs through a check state that also reads the current sample, a read state
// for the next sample, an interpolation state, the tick, velocity and makeup gain
// steps and an emit state that writes the output register; the next command is taken
// only after the tick is back in idle. A tick on a finished voice, or with zero
// length or step, or past the source end with looping off, skips from the check state
// to emit and gives silence. At or past the end with looping on, check subtracts one
// length per pass. The single RAM read port is why the two samples are read apart.
// The output register holds a result while res stalls; the next command is still
// taken, and a tick then waits in its emit cycle until the register frees.
// Reset loads the register defaults, clears the position and marks the voice done;
// the sample RAM is not cleared, so read only entries that were written.
module fractional_sample_player_top #(
	parameter int STORE_DEPTH = 65536,
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	fsp_cmd_if.sink   cmd,
	fsp_res_if.source res,
	fsp_cfg_if.sink   cfg
);
	import fsp_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int PW = LEN_W + 1 + FRACTION_BITS;
	localparam int IPW = PW - FRACTION_BITS;
	localparam int PRW = FRACTION_BITS + 18;
	localparam int ROUND_HALF = 1 << (FRACTION_BITS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_RD2  = 3'd2;
	localparam logic [2:0] ST_INT  = 3'd3;
	localparam logic [2:0] ST_GAIN = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]           state_q;
	logic [LEN_W-1:0]     source_length_q;
	logic                 loop_enable_q;
	logic [STEP_W-1:0]    pitch_step_q;
	logic                 source_stereo_q;
	logic [15:0]          velocity_gain_q;
	logic [15:0]          makeup_gain_q;
	logic [PW-1:0]        pos_q;
	logic                 done_q;
	logic [15:0]          tick_gain_q;
	logic                 env_q;
	logic                 silent_q;
	logic [1:0]           gstep_q;
	logic [31:0]          w1_q;
	logic signed [GW-1:0] l_q;
	logic signed [GW-1:0] r_q;
	logic                 out_valid_q;
	res_t                 out_data_q;

	logic                 cmd_acc;
	logic                 out_free;
	logic                 ram_we;
	logic [AW-1:0]        raddr;
	logic [31:0]          rdata;
	logic [LEN_W-1:0]     len_w;
	logic [PW-1:0]        end_w;
	logic [PW-1:0]        pos_adv;
	logic [IPW-1:0]       ip_w;
	logic [IPW-1:0]       nx_w;
	logic                 fin_w;
	logic [15:0]          gain_sel;
	logic [15:0]          s2r_w;
	logic [15:0]          s1r_w;
	logic signed [GW:0]   mix_sum;
	res_t                 res_next;

	function automatic logic signed [GW-1:0] interp(input logic signed [15:0] s1,
			input logic signed [15:0] s2, input logic [FRACTION_BITS-1:0] frac);
		logic signed [16:0]    d;
		logic signed [PRW-1:0] p;
		d = $signed({s2[15], s2}) - $signed({s1[15], s1});
		p = $signed({1'b0, frac}) * d;
		p = p + PRW'(ROUND_HALF);
		return GW'(p >>> FRACTION_BITS) + GW'(s1);
	endfunction

	assign cmd_acc = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !out_valid_q || res.ready;

	// Effective length is the register clamped to the RAM depth
	assign len_w = (32'(source_length_q) > 32'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH)
		: source_length_q;
	assign end_w = PW'({len_w, {FRACTION_BITS{1'b0}}});
	assign pos_adv = pos_q + PW'(pitch_step_q);
	assign ip_w = IPW'(pos_q >> FRACTION_BITS);
	assign nx_w = ((ip_w + IPW'(1)) < IPW'(len_w)) ? ip_w + IPW'(1) : IPW'(len_w) - IPW'(1);
	assign fin_w = (!loop_enable_q && (pos_adv >= end_w)) || !env_q;

	assign ram_we = cmd_acc && (cmd.data.op == OP_WRITE)
		&& (32'(cmd.data.write_index) < 32'(STORE_DEPTH));
	assign raddr = (state_q == ST_RD2) ? AW'(nx_w) : AW'(ip_w);

	fsp_ram #(
		.WIDTH(32),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cmd.data.write_index)),
		.wdata ({cmd.data.write_right, cmd.data.write_left}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Mono sources feed the left samples to the right lane
	assign s1r_w = source_stereo_q ? w1_q[31:16] : w1_q[15:0];
	assign s2r_w = source_stereo_q ? rdata[31:16] : rdata[15:0];

	always_comb begin
		case (gstep_q)
			G_TICK:  gain_sel = tick_gain_q;
			G_VEL:   gain_sel = velocity_gain_q;
			default: gain_sel = makeup_gain_q;
		endcase
	end

	always_comb begin
		mix_sum = (GW+1)'(l_q) + (GW+1)'(r_q);
		res_next = '0;
		res_next.finished = 1'b1;
		if (!silent_q) begin
			res_next.out_left = sat16(l_q);
			res_next.out_right = sat16(r_q);
			res_next.out_mix = sat16(GW'(mix_sum >>> 1));
			res_next.finished = fin_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_length_q <= LEN_W'(65536);
			loop_enable_q <= 1'b0;
			pitch_step_q <= STEP_W'(65536);
			source_stereo_q <= 1'b1;
			velocity_gain_q <= 16'd32768;
			makeup_gain_q <= 16'd32768;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_SOURCE_LENGTH: source_length_q <= cfg.data[LEN_W-1:0];
				CFG_LOOP_ENABLE:   loop_enable_q <= cfg.data[0];
				CFG_PITCH_STEP:    pitch_step_q <= cfg.data[STEP_W-1:0];
				CFG_SOURCE_STEREO: source_stereo_q <= cfg.data[0];
				CFG_VELOCITY_GAIN: velocity_gain_q <= cfg.data[15:0];
				CFG_MAKEUP_GAIN:   makeup_gain_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			done_q <= 1'b1;
			silent_q <= 1'b0;
			gstep_q <= G_TICK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						case (cmd.data.op)
							OP_START: begin
								pos_q <= '0;
								done_q <= 1'b0;
							end
							OP_TICK: state_q <= ST_CHK;
							default: ;
						endcase
					end
				end
				ST_CHK: begin
					if (done_q || (len_w == '0) || (pitch_step_q == '0)) begin
						silent_q <= 1'b1;
						state_q <= ST_EMIT;
					end else if (pos_q >= end_w) begin
						// wrap one length per cycle until back inside the source
						if (loop_enable_q) begin
							pos_q <= pos_q - end_w;
						end else begin
							silent_q <= 1'b1;
							state_q <= ST_EMIT;
						end
					end else begin
						silent_q <= 1'b0;
						state_q <= ST_RD2;
					end
				end
				ST_RD2: state_q <= ST_INT;
				ST_INT: begin
					gstep_q <= G_TICK;
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					if (gstep_q == G_MAKEUP)
						state_q <= ST_EMIT;
					else
						gstep_q <= gstep_q + 2'd1;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (silent_q) begin
							done_q <= 1'b1;
						end else begin
							pos_q <= pos_adv;
							if (fin_w)
								done_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: latched tick fields, current sample, lanes
	always_ff @(posedge clk) begin
		if (cmd_acc && (state_q == ST_IDLE)) begin
			tick_gain_q <= cmd.data.tick_gain;
			env_q <= cmd.data.envelope_active;
		end
		if (state_q == ST_RD2)
			w1_q <= rdata;
		if (state_q == ST_INT) begin
			l_q <= interp(w1_q[15:0], rdata[15:0], pos_q[FRACTION_BITS-1:0]);
			r_q <= interp(s1r_w, s2r_w, pos_q[FRACTION_BITS-1:0]);
		end else if (state_q == ST_GAIN) begin
			l_q <= gain_mul(l_q, gain_sel);
			r_q <= gain_mul(r_q, gain_sel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((state_q == ST_EMIT) && out_free)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free)
			out_data_q <= res_next;
	end

	assign res.valid = out_valid_q;
	assign res.data = out_data_q;

`ifndef SYNTHESIS
	a_write_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("sample RAM written outside idle");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && res.valid && !res.ready) |=> (state_q == ST_EMIT))
		else $error("tick left emit while output register was full");

	a_start_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && (cmd.data.op == OP_START)) |=> (!done_q && (pos_q == '0)))
		else $error("start transaction did not rewind the voice");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD2) |-> ((pos_q < end_w) && (nx_w < IPW'(len_w))))
		else $error("sample read beyond source length");

	a_gain_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GAIN) |-> (gstep_q != 2'd3))
		else $error("gain step counter overran");
`endif
endmodule

// File: hw/rtl/fsp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module fsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: dv/testbench.sv
// Self-checking testbench of the fractional sample player: predicts every tick result.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fsp_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [16:0] length;
		bit          wrap;
		logic [20:0] step;
		bit          stereo;
		logic [15:0] velocity;
		logic [15:0] makeup;
	} voice_setup_t;

	// Voice predictor and the queue of rendered frames still owed by the block
	class voice_model;
		localparam longint unsigned DEPTH = 65536;
		localparam int FRAC = 16;

		bit [31:0]   samples [int unsigned];
		logic [32:0] position;
		bit          done;
		logic [16:0] length_reg;
		bit          loop_on;
		logic [20:0] step_reg;
		bit          stereo_on;
		logic [15:0] vel_gain;
		logic [15:0] mk_gain;
		res_t        pending_frames [$];
		int          errors;

		function new();
			position = '0;
			done = 1'b1;
			length_reg = 17'd65536;
			loop_on = 1'b0;
			step_reg = 21'd65536;
			stereo_on = 1'b1;
			vel_gain = 16'd32768;
			mk_gain = 16'd32768;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_SOURCE_LENGTH: length_reg = v[16:0];
				CFG_LOOP_ENABLE:   loop_on = v[0];
				CFG_PITCH_STEP:    step_reg = v[20:0];
				CFG_SOURCE_STEREO: stereo_on = v[0];
				CFG_VELOCITY_GAIN: vel_gain = v[15:0];
				CFG_MAKEUP_GAIN:   mk_gain = v[15:0];
				default: ;
			endcase
		endfunction

		function longint unsigned span();
			return (length_reg > DEPTH) ? DEPTH : longint'(length_reg);
		endfunction

		// Store entries the next tick reads; 0 when it renders silence
		function bit tick_addresses(output int unsigned lo_idx, output int unsigned hi_idx);
			longint unsigned len, lim, p;
			len = span();
			lim = len << FRAC;
			p = 64'(position);
			if (done || len == 0 || step_reg == 0 || (p >= lim && !loop_on))
				return 1'b0;
			p = p % lim;
			lo_idx = 32'(p >> FRAC);
			hi_idx = (64'(lo_idx) + 1 < len) ? lo_idx + 1 : 32'(len - 1);
			return 1'b1;
		endfunction

		function longint lerp(logic signed [15:0] a, logic signed [15:0] b, logic [15:0] frac);
			longint prod;
			prod = longint'({1'b0, frac}) * (longint'(b) - longint'(a))
				+ (longint'(1) << (FRAC - 1));
			return longint'(a) + (prod >>> FRAC);
		endfunction

		function longint scale(longint x, logic [15:0] g);
			return (x * longint'({1'b0, g}) + 16384) >>> 15;
		endfunction

		function logic signed [15:0] clip(longint x);
			if (x > 32767)
				return 16'h7fff;
			if (x < -32768)
				return 16'h8000;
			return x[15:0];
		endfunction

		function void accept_command(cmd_t c);
			res_t            f;
			int unsigned     i0, i1;
			longint unsigned lim;
			longint          l, r;
			logic [31:0]     w0, w1;
			case (c.op)
				OP_WRITE: samples[c.write_index] = {c.write_right, c.write_left};
				OP_START: begin
					position = '0;
					done = 1'b0;
				end
				OP_TICK: begin
					f = '0;
					f.finished = 1'b1;
					lim = span() << FRAC;
					if (!tick_addresses(i0, i1)) begin
						done = 1'b1;
					end else begin
						position = 33'(position % lim);
						w0 = samples[i0];
						w1 = samples[i1];
						l = lerp(w0[15:0], w1[15:0], position[15:0]);
						r = stereo_on ? lerp(w0[31:16], w1[31:16], position[15:0]) : l;
						l = scale(scale(scale(l, c.tick_gain), vel_gain), mk_gain);
						r = scale(scale(scale(r, c.tick_gain), vel_gain), mk_gain);
						f.out_left = clip(l);
						f.out_right = clip(r);
						f.out_mix = clip((l + r) >>> 1);
						position = position + step_reg;
						f.finished = (!loop_on && position >= lim) || !c.envelope_active;
						done = f.finished;
					end
					pending_frames.push_back(f);
				end
				default: ;
			endcase
		endfunction

		function void note_error(string what, longint want, longint got);
			errors++;
			if (errors <= 10)
				$display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
		endfunction

		function void check_frame(res_t got);
			res_t want;
			if (pending_frames.size() == 0) begin
				note_error("unexpected result, left", 0, got.out_left);
				return;
			end
			want = pending_frames.pop_front();
			if (got.out_left !== want.out_left)
				note_error("out_left", want.out_left, got.out_left);
			if (got.out_right !== want.out_right)
				note_error("out_right", want.out_right, got.out_right);
			if (got.out_mix !== want.out_mix)
				note_error("out_mix", want.out_mix, got.out_mix);
			if (got.finished !== want.finished)
				note_error("finished", want.finished, got.finished);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fsp_cmd_if cmd_ch();
	fsp_res_if res_ch();
	fsp_cfg_if cfg_ch();

	voice_model voice = new();

	bit hold_off_req = 1'b0;
	int gap_pct = 0;
	int stall_pct = 0;

	fractional_sample_player_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready)
			voice.check_frame(res_ch.data);

	// Result receiver: random stalls, plus one long hold-off on request
	initial begin
		bit held;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req && !held) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if ($urandom_range(0, 99) < stall_pct) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'd32768;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cmd_t random_fields(input logic [1:0] op);
		cmd_t c;
		c.op = op;
		c.write_index = 16'($urandom);
		c.write_left = pick_sample();
		c.write_right = pick_sample();
		c.tick_gain = 16'($urandom);
		c.envelope_active = 1'($urandom);
		return c;
	endfunction

	// Offer one command and hold it until the block takes the transaction
	task automatic send(input cmd_t c);
		if ($urandom_range(0, 99) < gap_pct) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		voice.accept_command(c);
	endtask

	task automatic store_sample(input int unsigned idx, input logic [15:0] left,
			input logic [15:0] right);
		cmd_t c;
		c = random_fields(OP_WRITE);
		c.write_index = idx[15:0];
		c.write_left = left;
		c.write_right = right;
		send(c);
	endtask

	// Fill any store entry the tick would read before sending it
	task automatic play_tick(input logic [15:0] gain, input bit active);
		cmd_t        c;
		int unsigned a, b;
		if (voice.tick_addresses(a, b)) begin
			if (!voice.samples.exists(a))
				store_sample(a, pick_sample(), pick_sample());
			if (!voice.samples.exists(b))
				store_sample(b, pick_sample(), pick_sample());
		end
		c = random_fields(OP_TICK);
		c.tick_gain = gain;
		c.envelope_active = active;
		send(c);
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (voice.pending_frames.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic apply_setup(input voice_setup_t s);
		logic [CFG_IDX_W-1:0]  idx [6];
		logic [CFG_DATA_W-1:0] val [6];
		idx = '{CFG_SOURCE_LENGTH, CFG_LOOP_ENABLE, CFG_PITCH_STEP, CFG_SOURCE_STEREO,
			CFG_VELOCITY_GAIN, CFG_MAKEUP_GAIN};
		val = '{CFG_DATA_W'(s.length), CFG_DATA_W'(s.wrap), s.step, CFG_DATA_W'(s.stereo),
			CFG_DATA_W'(s.velocity), CFG_DATA_W'(s.makeup)};
		for (int i = 0; i < 6; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data <= val[i];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			voice.write_reg(idx[i], val[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic voice_setup_t pick_setup(input int ph);
		voice_setup_t s;
		s.length = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(16, 65536))
			: 17'($urandom_range(16, 96));
		s.wrap = 1'($urandom);
		case ($urandom_range(0, 2))
			0: s.step = 21'($urandom_range(1, 131072));
			1: s.step = 21'($urandom_range(1, 1048576));
			default: s.step = 21'($urandom_range(32768, 98304));
		endcase
		s.stereo = 1'($urandom);
		s.velocity = pick_gain();
		s.makeup = pick_gain();
		case (ph)
			0: s = '{17'd16, 1'b0, 21'h18000, 1'b0, 16'hffff, 16'hffff};
			1: s = '{17'd16, 1'b1, 21'd1048576, 1'b1, 16'hffff, 16'd0};
			2: s = '{17'd0, 1'b1, 21'd65536, 1'b1, 16'd32768, 16'd32768};
			3: s = '{17'd40, 1'b0, 21'd0, 1'b1, 16'd32768, 16'd32768};
			4: s = '{17'h1ffff, 1'b1, 21'd1048576, 1'b1, s.velocity, s.makeup};
			5: s = '{17'd65536, 1'b0, 21'd1, 1'b0, 16'd0, 16'd32768};
			default: ;
		endcase
		return s;
	endfunction

	// Mostly start-then-tick sequences, with stray writes, restarts and unused codes
	task automatic run_phase(input int count);
		int roll;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if ((voice.done && roll < 70) || roll < 3)
				send(random_fields(OP_START));
			else if (roll < 9)
				send(random_fields(OP_WRITE));
			else if (roll < 11)
				send(random_fields(OP_UNUSED));
			else
				play_tick(pick_gain(), $urandom_range(0, 19) != 0);
		end
	endtask

	initial begin
		voice_setup_t s;
		int           waited;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: done voice after reset, unused code, extreme samples and gains
		play_tick(16'd32768, 1'b1);
		send(random_fields(OP_UNUSED));
		store_sample(0, 16'h8000, 16'h7fff);
		store_sample(1, 16'h7fff, 16'h8000);
		store_sample(65535, 16'hffff, 16'h0000);
		send(random_fields(OP_START));
		play_tick(16'hffff, 1'b1);
		play_tick(16'd0, 1'b1);
		play_tick(16'd32768, 1'b0);
		play_tick(16'd32768, 1'b1);
		send(random_fields(OP_START));

		for (int ph = 0; ph < 14; ph++) begin
			drain();
			s = pick_setup(ph);
			apply_setup(s);
			gap_pct = (ph % 3 == 0 || ph >= 12) ? 0 : 12;
			stall_pct = (ph % 4 == 1 || ph >= 12) ? 0 : 10;
			if (ph == 7) begin
				gap_pct = 0;
				hold_off_req = 1'b1;
			end
			if (ph == 0) begin
				send(random_fields(OP_START));
				repeat (12) play_tick(16'hffff, 1'b1);
			end
			run_phase((s.length == 0 || s.step == 0) ? 25 : 120);
		end

		cmd_ch.valid <= 1'b0;
		waited = 0;
		while (voice.pending_frames.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (voice.pending_frames.size() != 0)
			voice.note_error("results never arrived", voice.pending_frames.size(), 0);
		if (voice.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_if.sv
hw/rtl/fsp_ram.sv
hw/rtl/fractional_sample_player_top.sv
dv/testbench.sv
